@@ hw/rtl/mdlb_pkg.sv @@
package mdlb_pkg;

  // Field widths
  localparam int unsigned CodeW    = 4;
  localparam int unsigned StepW    = 4;
  localparam int unsigned ElapsedW = 12;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  // Register map (byte addresses)
  localparam logic [AddrW-1:0] RegLedInverted = 3'd0;

  // Status codes
  localparam logic [CodeW-1:0] CodeRunning     = 4'd0;
  localparam logic [CodeW-1:0] CodeMorseLast   = 4'd10;
  localparam logic [CodeW-1:0] CodeDotsLast    = 4'd5;
  localparam logic [CodeW-1:0] CodeConfiguring = 4'd11;
  localparam logic [CodeW-1:0] CodeConfigMatch = 4'd12;

  // Pattern lengths
  localparam logic [StepW-1:0] StepsShort = 4'd2;
  localparam logic [StepW-1:0] StepsMorse = 4'd10;
  localparam logic [StepW-1:0] StepsNone  = 4'd0;
  localparam logic [StepW-1:0] StepPause  = 4'd9;

  // Step durations in milliseconds
  localparam logic [ElapsedW-1:0] ElapsedMax  = 12'd4095;
  localparam logic [ElapsedW-1:0] MsPause     = 12'd3000;
  localparam logic [ElapsedW-1:0] MsMatchOn   = 12'd1000;
  localparam logic [ElapsedW-1:0] MsMatchOff  = 12'd200;
  localparam logic [ElapsedW-1:0] MsBeatOn    = 12'd100;
  localparam logic [ElapsedW-1:0] MsBeatOff   = 12'd2000;
  localparam logic [ElapsedW-1:0] MsDotOn     = 12'd200;
  localparam logic [ElapsedW-1:0] MsDotOff    = 12'd300;
  localparam logic [ElapsedW-1:0] MsDotGap    = 12'd600;
  localparam logic [ElapsedW-1:0] MsDashOn    = 12'd800;
  localparam logic [ElapsedW-1:0] MsDashOff   = 12'd400;
  localparam logic [ElapsedW-1:0] MsZero      = 12'd0;

  typedef struct packed {
    logic [CodeW-1:0] status_code;
    logic             tick;
  } in_item_t;

  typedef struct packed {
    logic             led_on;
    logic [StepW-1:0] step_index;
  } out_item_t;

  // Number of steps in the pattern of a code
  function automatic logic [StepW-1:0] step_count(input logic [CodeW-1:0] code);
    logic [StepW-1:0] n;
    if (code == CodeConfiguring || code == CodeConfigMatch || code == CodeRunning) begin
      n = StepsShort;
    end else if (code <= CodeMorseLast) begin
      n = StepsMorse;
    end else begin
      n = StepsNone;
    end
    return n;
  endfunction

  // Duration of one step of a code's pattern
  function automatic logic [ElapsedW-1:0] step_duration(input logic [CodeW-1:0] code,
                                                        input logic [StepW-1:0] step);
    logic [CodeW-1:0]    pair;
    logic                second;
    logic                dot;
    logic [ElapsedW-1:0] dur;
    pair   = {1'b0, step[StepW-1:1]};
    second = step[0];
    dot    = 1'b0;
    dur    = MsZero;
    if (code == CodeConfiguring) begin
      dur = second ? MsZero : MsPause;
    end else if (code == CodeConfigMatch) begin
      dur = second ? MsMatchOff : MsMatchOn;
    end else if (code == CodeRunning) begin
      dur = second ? MsBeatOff : MsBeatOn;
    end else if (code > CodeMorseLast || step >= StepsMorse) begin
      dur = MsZero;
    end else if (step == StepPause) begin
      dur = MsPause;
    end else begin
      // dots first for low digits, dashes first for high digits
      if (code <= CodeDotsLast) begin
        dot = (pair < code);
      end else begin
        dot = (pair >= code - CodeDotsLast);
      end
      if (code <= CodeDotsLast && dot && second && (pair + 4'd1 == code)) begin
        dur = MsDotGap;
      end else if (dot) begin
        dur = second ? MsDotOff : MsDotOn;
      end else begin
        dur = second ? MsDashOff : MsDashOn;
      end
    end
    return dur;
  endfunction

endpackage

@@ hw/rtl/morse_digit_led_blinker.sv @@
// Status LED blinker: shows a status code as a Morse digit pattern.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
//   item, carrying the current status code and a one-millisecond tick flag.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result
//   transaction per input item, with the LED level and the pattern step.
// Configuration: APB-style port, one register (led_inverted) at offset 0;
//   writes take the usual setup and access cycles, pready is tied high.
// Throughput: one item per cycle while the result is not stalled. An accepted
//   item sits in the input register, then step evaluation loads the result
//   register; the pattern state updates in the same cycle as the result.
// Stalls: a stalled result holds in the result register while one more item
//   can still be taken into the input register; with both full, in_stall_o
//   rises in the same cycle as out_stall_i.
// Reset: asynchronous, active low; clears both pipeline stages, the pattern
//   state and the register, so the first item after reset restarts the
//   pattern at step 0.
module morse_digit_led_blinker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mdlb_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output mdlb_pkg::out_item_t        out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mdlb_pkg::AddrW-1:0] paddr,
  input  logic [mdlb_pkg::DataW-1:0] pwdata,
  output logic [mdlb_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import mdlb_pkg::*;

  logic led_inverted;

  // Configuration register
  mdlb_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .led_inverted_o (led_inverted)
  );

  // Pattern engine and pipeline
  mdlb_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .led_inverted_i (led_inverted),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

@@ hw/rtl/mdlb_regs.sv @@
module mdlb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mdlb_pkg::AddrW-1:0] paddr,
  input  logic [mdlb_pkg::DataW-1:0] pwdata,
  output logic [mdlb_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output logic                       led_inverted_o
);
  import mdlb_pkg::*;

  logic led_inverted_q;
  logic led_inverted_d;
  logic reg_sel;
  logic wr_en;

  // Only one register; upper offsets are unmapped
  assign reg_sel = (paddr[AddrW-1] == RegLedInverted[AddrW-1]);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;

  always_comb begin
    led_inverted_d = led_inverted_q;
    if (wr_en) begin
      led_inverted_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_inverted_q <= 1'b0;
    end else begin
      led_inverted_q <= led_inverted_d;
    end
  end

  // Read back
  assign prdata         = reg_sel ? {{(DataW-1){1'b0}}, led_inverted_q} : '0;
  assign led_inverted_o = led_inverted_q;

endmodule

@@ hw/rtl/mdlb_core.sv @@
module mdlb_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 led_inverted_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mdlb_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mdlb_pkg::out_item_t  out_data_o
);
  import mdlb_pkg::*;

  // Pipeline registers
  logic      in_valid_q, in_valid_d;
  in_item_t  in_q, in_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  // Pattern state
  logic                shown_valid_q, shown_valid_d;
  logic [CodeW-1:0]    code_q, code_d;
  logic [StepW-1:0]    step_q, step_d;
  logic                level_q, level_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;

  logic                advance;
  logic                proc;
  logic                restart;
  logic                step_done;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [StepW-1:0]    cur_step;
  logic [StepW-1:0]    step_inc;
  logic                cur_level;
  logic [ElapsedW-1:0] dur;

  // Handshake: result stage loads when empty or drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign proc       = in_valid_q && advance;

  // Step evaluation for the registered item
  always_comb begin
    elapsed_inc = elapsed_q;
    if (in_q.tick && elapsed_q != ElapsedMax) begin
      elapsed_inc = elapsed_q + 12'd1;
    end
    restart   = !shown_valid_q || (in_q.status_code != code_q);
    cur_step  = restart ? '0 : step_q;
    cur_level = restart ? !led_inverted_i : level_q;
    dur       = step_duration(in_q.status_code, cur_step);
    step_done = (elapsed_inc >= dur);
    step_inc  = cur_step + 4'd1;
    if (step_inc >= step_count(in_q.status_code)) begin
      step_inc = '0;
    end
  end

  // Next state
  always_comb begin
    in_valid_d    = in_valid_q;
    in_d          = in_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    shown_valid_d = shown_valid_q;
    code_d        = code_q;
    step_d        = step_q;
    level_d       = level_q;
    elapsed_d     = elapsed_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        in_d = in_data_i;
      end
    end
    if (advance) begin
      out_valid_d = in_valid_q;
    end
    if (proc) begin
      shown_valid_d = 1'b1;
      code_d        = in_q.status_code;
      step_d        = step_done ? step_inc : cur_step;
      level_d       = step_done ? !cur_level : cur_level;
      elapsed_d     = step_done ? '0 : elapsed_inc;
      out_d.led_on     = level_d;
      out_d.step_index = step_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      shown_valid_q <= 1'b0;
      step_q        <= '0;
      level_q       <= 1'b0;
      elapsed_q     <= '0;
    end else begin
      in_valid_q    <= in_valid_d;
      out_valid_q   <= out_valid_d;
      shown_valid_q <= shown_valid_d;
      step_q        <= step_d;
      level_q       <= level_d;
      elapsed_q     <= elapsed_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    out_q  <= out_d;
    code_q <= code_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_shown_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_valid_q |=> shown_valid_q)
    else $error("shown code lost its valid flag");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_valid_q |-> (step_q == '0 || step_q < step_count(code_q)))
    else $error("step index beyond pattern length");

  a_step_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !restart && !step_done) |=> (step_q == $past(step_q) && level_q == $past(level_q)))
    else $error("step moved before its duration elapsed");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> (out_valid_q && out_q.step_index == step_q && out_q.led_on == level_q))
    else $error("result register does not match pattern state");
`endif

endmodule
